// ===== hdl/bfm_pkg.sv =====
package bfm_pkg;

    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_DEPTH = 32768;
    localparam int PA_W = $clog2(PROG_DEPTH);
    localparam int TA_W = $clog2(TAPE_DEPTH);
    localparam int LEN_W = 13;
    localparam int PC_W = 13;
    localparam int PTR_W = 15;
    localparam int ADDR_W = 12;
    localparam int MATCH_W = 12;
    localparam int OP_W = 4;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam logic [OP_W-1:0] OP_OUT   = 4'd0;
    localparam logic [OP_W-1:0] OP_IN    = 4'd1;
    localparam logic [OP_W-1:0] OP_LEFT  = 4'd2;
    localparam logic [OP_W-1:0] OP_RIGHT = 4'd3;
    localparam logic [OP_W-1:0] OP_MINUS = 4'd4;
    localparam logic [OP_W-1:0] OP_PLUS  = 4'd5;
    localparam logic [OP_W-1:0] OP_OPEN  = 4'd6;
    localparam logic [OP_W-1:0] OP_CLOSE = 4'd7;

    // queued command word between front and back
    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_W-1:0]    addr;
        logic [OP_W-1:0]      op;
        logic [MATCH_W-1:0]   match;
        logic [7:0]           in_byte;
        logic                 in_valid;
        logic                 in_eof;
    } t_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/bfm_front.sv =====
// 2-entry queue toward the execution unit.
module bfm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bfm_pkg::t_item i_item,
    output logic           o_q_valid,
    output bfm_pkg::t_item o_q_item,
    input  logic           i_q_pop
);
    import bfm_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== hdl/bfm_back.sv =====
// Executes queued commands against program store and tape.
module bfm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bfm_pkg::LEN_W-1:0] i_length,
    input  logic                      i_q_valid,
    input  bfm_pkg::t_item            i_q_item,
    output logic                      o_q_pop,
    output logic                      o_busy,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_res_out_valid,
    output logic [7:0]                o_res_out_byte,
    output logic                      o_res_input_taken,
    output logic                      o_res_needs_input,
    output logic                      o_res_halted,
    output logic [bfm_pkg::PC_W-1:0]  o_res_pc_now,
    output logic [bfm_pkg::PTR_W-1:0] o_res_cell_index
);
    import bfm_pkg::*;

    logic [15:0]      r_prog [PROG_DEPTH];
    logic [7:0]       r_tape [TAPE_DEPTH];
    logic [15:0]      r_word;
    logic [7:0]       r_cell;
    t_state           r_state, n_state;
    logic [TA_W-1:0]  r_clr;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    t_item            r_cur;
    logic             r_ov, n_ov, r_tk, n_tk, r_nd, n_nd;
    logic [7:0]       r_ob, n_ob;
    logic             r_outv;
    logic [LEN_W-1:0] eff_len;
    logic             tape_we;
    logic [7:0]       tape_wd;
    logic [TA_W-1:0]  tape_wa;
    logic             run;
    logic [OP_W-1:0]  wop;
    logic [MATCH_W-1:0] wmatch;
    logic             accept;

    assign eff_len = (i_length > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH) : i_length;
    assign run     = (r_pc < PC_W'(eff_len));
    assign wop     = r_word[15:12];
    assign wmatch  = r_word[11:0];
    assign accept  = (r_state == ST_IDLE) && i_q_valid && (!r_outv || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == TA_W'(TAPE_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_q_item.cmd == CMD_STEP && run) ? ST_FETCH : ST_OUT;
                end
            end
            ST_FETCH: n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath results
    always_comb begin
        n_pc    = r_pc;
        n_ptr   = r_ptr;
        n_ov    = r_ov;
        n_ob    = r_ob;
        n_tk    = r_tk;
        n_nd    = r_nd;
        tape_we = 1'b0;
        tape_wd = 8'd0;
        tape_wa = r_ptr[TA_W-1:0];
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                tape_we = 1'b1;
                tape_wa = r_clr;
            end
            ST_IDLE: begin
                if (accept) begin
                    o_q_pop = 1'b1;
                    n_ov = 1'b0; n_ob = 8'd0; n_tk = 1'b0; n_nd = 1'b0;
                    if (i_q_item.cmd == CMD_RESTART) begin
                        n_pc  = '0;
                        n_ptr = '0;
                    end
                end
            end
            ST_EXEC: begin
                n_pc = r_pc + PC_W'(1);
                case (wop)
                    OP_OUT: begin
                        n_ov = 1'b1;
                        n_ob = r_cell;
                    end
                    OP_IN: begin
                        if (r_cur.in_valid) begin
                            tape_we = 1'b1;
                            tape_wd = r_cur.in_eof ? 8'd0 : r_cur.in_byte;
                            n_tk    = 1'b1;
                        end else begin
                            n_nd = 1'b1;
                            n_pc = r_pc;
                        end
                    end
                    OP_LEFT:  n_ptr = PTR_W'(r_ptr[TA_W-1:0] - TA_W'(1));
                    OP_RIGHT: n_ptr = PTR_W'(r_ptr[TA_W-1:0] + TA_W'(1));
                    OP_MINUS: begin
                        tape_we = 1'b1;
                        tape_wd = r_cell - 8'd1;
                    end
                    OP_PLUS: begin
                        tape_we = 1'b1;
                        tape_wd = r_cell + 8'd1;
                    end
                    OP_OPEN:  if (r_cell == 8'd0) n_pc = PC_W'(wmatch) + PC_W'(1);
                    OP_CLOSE: if (r_cell != 8'd0) n_pc = PC_W'(wmatch) + PC_W'(1);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_q_item.cmd == CMD_LOAD) begin
            r_prog[i_q_item.addr[PA_W-1:0]] <= {i_q_item.op, i_q_item.match};
        end
        r_word <= r_prog[r_pc[PA_W-1:0]];
        if (tape_we) begin
            r_tape[tape_wa] <= tape_wd;
        end
        r_cell <= r_tape[r_ptr[TA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_cur <= i_q_item;
        r_ob <= n_ob;
        r_ov <= n_ov;
        r_tk <= n_tk;
        r_nd <= n_nd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_ptr   <= '0;
            r_outv  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + TA_W'(1);
            r_pc  <= n_pc;
            r_ptr <= n_ptr;
            if (r_state == ST_OUT) r_outv <= 1'b1;
            else if (!i_out_stall) r_outv <= 1'b0;
        end
    end

    // result register updates only when output slot free (checked at accept)
    assign o_out_valid       = r_outv;
    assign o_busy            = (r_state != ST_IDLE);
    assign o_res_out_valid   = r_ov;
    assign o_res_out_byte    = r_ob;
    assign o_res_input_taken = r_tk;
    assign o_res_needs_input = r_nd;
    assign o_res_halted      = !run;
    assign o_res_pc_now      = r_pc;
    assign o_res_cell_index  = r_ptr;

endmodule

// ===== hdl/brainfuck_machine_step.sv =====
// Brainfuck machine, one command word per input handshake.
// Input channel: i_valid / o_stall with fields i_command, i_prog_addr,
// i_prog_op, i_prog_match, i_in_byte, i_in_valid, i_in_eof.
// Commands: load a program word, execute one step, restart pc and pointer, or none.
// Output channel: o_valid / i_stall, one result word per input word.
// Config channel: i_cfg_valid / o_cfg_ready writes program_length; write
// only while idle.
// Words pass a 2-entry queue into the executor. A step passes accept,
// program and tape read, execute and result; load, restart, none and
// halted steps pass accept and result only.
// With an empty queue and a ready receiver, o_valid rises once a word
// has passed the queue, the executor states and the output register.
// Result fields stay valid and stable until taken; a stalled output
// keeps the executor from accepting its next word, and the queue then
// fills and raises o_stall.
// After reset the tape is cleared one cell a cycle, all 32768 cells,
// during which no word leaves the queue (config writes still accepted).
// Halted steps return state unchanged with halted set.
module brainfuck_machine_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_command,
    input  logic [bfm_pkg::ADDR_W-1:0]     i_prog_addr,
    input  logic [bfm_pkg::OP_W-1:0]       i_prog_op,
    input  logic [bfm_pkg::MATCH_W-1:0]    i_prog_match,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_in_valid,
    input  logic                           i_in_eof,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfm_pkg::LEN_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_out_valid,
    output logic [7:0]                     o_out_byte,
    output logic                           o_input_taken,
    output logic                           o_needs_input,
    output logic                           o_halted,
    output logic [bfm_pkg::PC_W-1:0]       o_pc_now,
    output logic [bfm_pkg::PTR_W-1:0]      o_cell_index
);
    import bfm_pkg::*;

    logic [LEN_W-1:0] r_length;
    t_item            in_item, q_item;
    logic             q_valid, q_pop, busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (i_cfg_valid) begin
            r_length <= i_cfg_data;
        end
    end

    always_comb begin
        in_item.cmd      = t_cmd'(i_command);
        in_item.addr     = i_prog_addr;
        in_item.op       = i_prog_op;
        in_item.match    = i_prog_match;
        in_item.in_byte  = i_in_byte;
        in_item.in_valid = i_in_valid;
        in_item.in_eof   = i_in_eof;
    end

    bfm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    bfm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_length          (r_length),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_busy            (busy),
        .o_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .o_res_out_valid   (o_out_valid),
        .o_res_out_byte    (o_out_byte),
        .o_res_input_taken (o_input_taken),
        .o_res_needs_input (o_needs_input),
        .o_res_halted      (o_halted),
        .o_res_pc_now      (o_pc_now),
        .o_res_cell_index  (o_cell_index)
    );

    // a pop needs a queued word
    a_pop_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    // executor never pops while busy
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !busy) else $error("pop while busy");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pc_now)
            && $stable(o_cell_index) && $stable(o_out_byte)))
        else $error("result changed under stall");

endmodule

// ===== bench/bfm_step_checker.sv =====
module bfm_step_checker
    import bfm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [ADDR_W-1:0]  i_prog_addr,
    input  logic [OP_W-1:0]    i_prog_op,
    input  logic [MATCH_W-1:0] i_prog_match,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_valid,
    input  logic               i_in_eof,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [LEN_W-1:0]   i_cfg_data,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic               o_out_valid,
    input  logic [7:0]         o_out_byte,
    input  logic               o_input_taken,
    input  logic               o_needs_input,
    input  logic               o_halted,
    input  logic [PC_W-1:0]    o_pc_now,
    input  logic [PTR_W-1:0]   o_cell_index,
    output int                 mismatch_count,
    output int                 pending_words,
    output int                 result_count
);

    typedef struct packed {
        logic              out_valid;
        logic [7:0]        out_byte;
        logic              input_taken;
        logic              needs_input;
        logic              halted;
        logic [PC_W-1:0]   pc_now;
        logic [PTR_W-1:0]  cell_index;
    } t_status;

    t_status            status_q[$];
    logic [15:0]        prog_words [PROG_DEPTH];
    logic [7:0]         cells [TAPE_DEPTH];
    logic [PC_W-1:0]    pc;
    logic [PTR_W-1:0]   ptr;
    logic [LEN_W-1:0]   prog_len;

    // executes one command word on the shadow machine
    function automatic t_status exec_word(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                          logic [OP_W-1:0] op, logic [MATCH_W-1:0] match,
                                          logic [7:0] in_byte, logic in_valid, logic in_eof);
        t_status          st;
        logic [PC_W-1:0]  eff;
        logic [PC_W-1:0]  next_pc;
        logic [15:0]      w;
        st = '0;
        eff = (prog_len > PROG_DEPTH) ? PC_W'(PROG_DEPTH) : prog_len;
        case (t_cmd'(cmd))
            CMD_LOAD: begin
                prog_words[addr] = {op, match};
            end
            CMD_RESTART: begin
                pc = '0;
                ptr = '0;
            end
            CMD_STEP: begin
                if (pc < eff) begin
                    w = prog_words[pc[ADDR_W-1:0]];
                    next_pc = pc + 1'b1;
                    case (w[15:12])
                        OP_OUT: begin
                            st.out_valid = 1'b1;
                            st.out_byte = cells[ptr];
                        end
                        OP_IN: begin
                            if (in_valid) begin
                                cells[ptr] = in_eof ? 8'd0 : in_byte;
                                st.input_taken = 1'b1;
                            end else begin
                                st.needs_input = 1'b1;
                                next_pc = pc;
                            end
                        end
                        OP_LEFT:  ptr = ptr - 1'b1;
                        OP_RIGHT: ptr = ptr + 1'b1;
                        OP_MINUS: cells[ptr] = cells[ptr] - 8'd1;
                        OP_PLUS:  cells[ptr] = cells[ptr] + 8'd1;
                        OP_OPEN:  if (cells[ptr] == 8'd0) next_pc = w[11:0] + 13'd1;
                        OP_CLOSE: if (cells[ptr] != 8'd0) next_pc = w[11:0] + 13'd1;
                        default: ;
                    endcase
                    pc = next_pc;
                end
            end
            default: ;
        endcase
        st.halted = (pc >= eff);
        st.pc_now = pc;
        st.cell_index = ptr;
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            foreach (cells[k]) cells[k] = 8'd0;
            pc = '0;
            ptr = '0;
            prog_len = '0;
            status_q.delete();
            mismatch_count = 0;
            result_count = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_out_valid, o_out_byte, o_input_taken, o_needs_input,
                       o_halted, o_pc_now, o_cell_index};
                result_count++;
                if (status_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %p", got);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                prog_len = i_cfg_data;
            if (i_valid && !o_stall)
                status_q.push_back(exec_word(i_command, i_prog_addr, i_prog_op,
                                             i_prog_match, i_in_byte, i_in_valid, i_in_eof));
        end
        pending_words = status_q.size();
    end

endmodule

// ===== bench/brainfuck_machine_step_tb.sv =====
module brainfuck_machine_step_tb;
    import bfm_pkg::*;

    // tape clear after reset alone covers all 32768 cells
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 1600;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_command;
    logic [ADDR_W-1:0]  i_prog_addr;
    logic [OP_W-1:0]    i_prog_op;
    logic [MATCH_W-1:0] i_prog_match;
    logic [7:0]         i_in_byte;
    logic               i_in_valid;
    logic               i_in_eof;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [LEN_W-1:0]   i_cfg_data;
    logic               o_valid;
    logic               i_stall;
    logic               o_out_valid;
    logic [7:0]         o_out_byte;
    logic               o_input_taken;
    logic               o_needs_input;
    logic               o_halted;
    logic [PC_W-1:0]    o_pc_now;
    logic [PTR_W-1:0]   o_cell_index;

    int mismatch_count;
    int pending_words;
    int result_count;
    int words_sent;
    int cycle_count;
    int tx_idle_pct;        // sender gap chance, percent per cycle
    int rx_stall_pct;       // receiver stall chance, percent per cycle
    int hold_left;
    bit hold_req;           // asks the stall process for one long hold-off

    brainfuck_machine_step dut (.*);

    bfm_step_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side: random stalls, or one long hold while the queue fills up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
            i_stall = 1'b1;
        end else begin
            i_stall = ($urandom_range(99) < rx_stall_pct);
        end
    end

    // one word on the input channel; valid stays up if the next word follows at once
    task automatic send_word(t_cmd cmd, logic [ADDR_W-1:0] addr, logic [OP_W-1:0] op,
                             logic [MATCH_W-1:0] match, logic [7:0] in_byte,
                             logic in_valid, logic in_eof);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_command = cmd;
        i_prog_addr = addr;
        i_prog_op = op;
        i_prog_match = match;
        i_in_byte = in_byte;
        i_in_valid = in_valid;
        i_in_eof = in_eof;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    // given command with every other field random
    task automatic send_random(t_cmd cmd);
        send_word(cmd, ADDR_W'($urandom), OP_W'($urandom), MATCH_W'($urandom),
                  8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // sender drops valid and waits until every result is back
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_words == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data = len;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic step_word(logic [7:0] in_byte, logic in_valid, logic in_eof);
        send_word(CMD_STEP, ADDR_W'($urandom), OP_W'($urandom), MATCH_W'($urandom),
                  in_byte, in_valid, in_eof);
    endtask

    task automatic set_idling();
        if (words_sent < 550) begin
            tx_idle_pct = 31;
            rx_stall_pct = 51;
        end else if (words_sent < 1100) begin
            tx_idle_pct = 51;
            rx_stall_pct = 31;
        end else begin
            tx_idle_pct = 0;
            rx_stall_pct = 0;
        end
    endtask

    initial begin
        logic [OP_W-1:0] op;
        logic [MATCH_W-1:0] match;
        int n;
        int steps;
        int r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_NONE;
        i_prog_addr = '0;
        i_prog_op = '0;
        i_prog_match = '0;
        i_in_byte = '0;
        i_in_valid = 1'b0;
        i_in_eof = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_stall = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        words_sent = 0;
        cycle_count = 0;
        tx_idle_pct = 31;
        rx_stall_pct = 51;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // length past the store depth clamps; no steps, since words are unwritten
        write_length(13'h1FFF);
        send_word(CMD_RESTART, '0, '0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_NONE, '1, '1, '1, '1, 1'b1, 1'b1);
        send_word(CMD_LOAD, 12'hFFF, 4'hF, 12'hFFF, 8'hFF, 1'b1, 1'b1);
        send_word(CMD_LOAD, 12'h000, OP_OUT, 12'h000, 8'h00, 1'b0, 1'b0);
        write_length(13'd4096);
        send_word(CMD_NONE, '0, '0, '0, '0, 1'b0, 1'b0);
        // zero length: a step is a halted no-op
        write_length(13'd0);
        step_word(8'h00, 1'b0, 1'b0);

        // hand-built program: plus, out, in (starve, then byte), in (eof),
        // left across zero, minus wrapping to 255, out, right, loop skip to halt
        send_word(CMD_LOAD, 12'd0, OP_PLUS,  '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd1, OP_OUT,   '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd2, OP_IN,    '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd3, OP_IN,    '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd4, OP_LEFT,  '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd5, OP_MINUS, '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd6, OP_OUT,   '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd7, OP_RIGHT, '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd8, OP_OPEN,  12'd9, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 12'd9, OP_CLOSE, 12'd8, '0, 1'b0, 1'b0);
        write_length(13'd10);
        for (int i = 0; i < 12; i++)
            step_word(8'hFF, i >= 3, i == 4);

        // first random block starts with a long output hold-off
        hold_req = 1'b1;
        while (words_sent < ITEM_TARGET) begin
            set_idling();
            n = ($urandom_range(99) < 10) ? $urandom_range(40, 64) : $urandom_range(1, 24);
            for (int a = 0; a < n; a++) begin
                r = $urandom_range(99);
                op = (r < 8) ? OP_OUT : (r < 18) ? OP_IN
                     : (r < 93) ? OP_W'($urandom_range(2, 8)) : OP_W'($urandom_range(9, 15));
                match = ($urandom_range(99) < 80) ? MATCH_W'($urandom_range(0, n - 1))
                        : MATCH_W'($urandom);
                send_word(CMD_LOAD, ADDR_W'(a), op, match, 8'($urandom), 1'($urandom),
                          1'($urandom));
            end
            write_length(LEN_W'(n));
            send_random(CMD_RESTART);
            steps = $urandom_range(10, 60);
            for (int s = 0; s < steps; s++) begin
                r = $urandom_range(99);
                if (r < 4)
                    send_random(CMD_RESTART);
                else if (r < 7)
                    send_random(CMD_LOAD);
                else if (r < 9)
                    send_random(CMD_NONE);
                else
                    step_word(8'($urandom), $urandom_range(99) < 70, $urandom_range(99) < 15);
            end
        end

        drain();
        $display("%0d command words sent, %0d result words checked", words_sent, result_count);
        $display("covered loads, steps of every opcode, restarts, input starvation and eof");
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
